// ===== sv/luma_difference_threshold_rle_unit_defines.svh =====
// assertion macros for the luma difference threshold run-length unit
// used by modules that need clk and rst in scope; no other dependencies
`ifndef LUMA_DIFFERENCE_THRESHOLD_RLE_UNIT_DEFINES_SVH
`define LUMA_DIFFERENCE_THRESHOLD_RLE_UNIT_DEFINES_SVH

// property that must hold at every edge out of reset
`define LDTR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("luma_dtr assertion failed");

// condition in one cycle implies a consequence in the next
`define LDTR_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("luma_dtr assertion failed");

`endif

// ===== sv/luma_dtr_pkg.sv =====
// shared types and constants of the luma difference threshold run-length unit
// no dependencies
package luma_dtr_pkg;

  // run length limit, capped by the 8-bit count
  localparam int RUN_LIMIT = 255;
  localparam logic [7:0] RUN_CAP = 8'((RUN_LIMIT > 255) ? 255 : RUN_LIMIT);

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  // classified pixel handed from front to back
  typedef struct packed {
    logic signed [7:0] diff;
    logic              eoi;
  } cmd_t;

endpackage

// ===== sv/luma_dtr_pixel_if.sv =====
// pixel request channel: two luma bytes and an end of image mark
// no dependencies
interface luma_dtr_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] main_luma;
  logic [7:0] compl_luma;
  logic       end_of_image;

  modport source (output valid, output main_luma, output compl_luma,
                  output end_of_image, input ready);
  modport sink (input valid, input main_luma, input compl_luma,
                input end_of_image, output ready);
endinterface

// ===== sv/luma_dtr_run_if.sv =====
// run request channel: run value, length and final flag
// no dependencies
interface luma_dtr_run_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] run_value;
  logic [7:0]        run_length;
  logic              final_run;

  modport source (output valid, output run_value, output run_length,
                  output final_run, input ready);
  modport sink (input valid, input run_value, input run_length,
                input final_run, output ready);
endinterface

// ===== sv/luma_dtr_cfg_if.sv =====
// configuration write channel for the similarity threshold
// no dependencies
interface luma_dtr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/luma_dtr_front.sv =====
// front stage: accepts pixels and forms the wrapped signed luma difference
// depends on luma_dtr_pkg and luma_dtr_pixel_if
module luma_dtr_front (
  input  logic                clk,
  input  logic                rst,
  luma_dtr_pixel_if.sink      pix,
  output logic                push,
  output luma_dtr_pkg::cmd_t  push_cmd,
  input  logic                push_ready
);

  logic              stage_valid;
  logic signed [7:0] stage_diff;
  logic              stage_eoi;
  logic              take;

  // stage frees up when empty or when the queue takes its request
  assign pix.ready = !stage_valid || push_ready;
  assign take      = pix.valid && pix.ready;

  assign push          = stage_valid;
  assign push_cmd.diff = stage_diff;
  assign push_cmd.eoi  = stage_eoi;

  // control state of the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (push_ready) begin
      stage_valid <= 1'b0;
    end
  end

  // difference wraps to a signed byte
  always_ff @(posedge clk) begin
    if (take) begin
      stage_diff <= $signed(8'(pix.main_luma - pix.compl_luma));
      stage_eoi  <= pix.end_of_image;
    end
  end

endmodule

// ===== sv/luma_dtr_fifo.sv =====
// short request queue between the front and the back
// depends on luma_dtr_pkg and the assertion macro header
`include "luma_difference_threshold_rle_unit_defines.svh"
module luma_dtr_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  luma_dtr_pkg::cmd_t  push_cmd,
  output logic                push_ready,
  output logic                pop_valid,
  output luma_dtr_pkg::cmd_t  pop_cmd,
  input  logic                pop
);

  luma_dtr_pkg::cmd_t                   mem [luma_dtr_pkg::Q_DEPTH];
  logic [luma_dtr_pkg::Q_AW-1:0]        wr_ptr;
  logic [luma_dtr_pkg::Q_AW-1:0]        rd_ptr;
  logic [luma_dtr_pkg::Q_CW-1:0]        count;
  logic                                 do_push;
  logic                                 do_pop;

  assign push_ready = count != luma_dtr_pkg::Q_CW'(luma_dtr_pkg::Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + luma_dtr_pkg::Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + luma_dtr_pkg::Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + luma_dtr_pkg::Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - luma_dtr_pkg::Q_CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  `LDTR_ASSERT(a_count_bound, count <= luma_dtr_pkg::Q_CW'(luma_dtr_pkg::Q_DEPTH))
  `LDTR_ASSERT(a_ptr_gap, (luma_dtr_pkg::Q_AW'(wr_ptr - rd_ptr)) == luma_dtr_pkg::Q_AW'(count))
  `LDTR_ASSERT_NEXT(a_push_fills, do_push && !do_pop, count != '0)

endmodule

// ===== sv/luma_dtr_back.sv =====
// back stage: run tracking, threshold register and the output register
// depends on luma_dtr_pkg, the run and cfg interfaces and the macro header
`include "luma_difference_threshold_rle_unit_defines.svh"
module luma_dtr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  luma_dtr_pkg::cmd_t  q_cmd,
  output logic                q_pop,
  luma_dtr_cfg_if.sink        cfg,
  luma_dtr_run_if.source      runs
);

  // run state
  logic [7:0]        threshold;
  logic signed [7:0] open_value;
  logic [7:0]        open_count;
  logic              run_active;

  // output register and the pending final run
  logic              out_valid;
  logic signed [7:0] out_value;
  logic [7:0]        out_length;
  logic              out_final;
  logic              pend_valid;
  logic signed [7:0] pend_value;

  logic signed [8:0] delta;
  logic [8:0]        mag;
  logic              similar;
  logic              brk;
  logic              need_out;
  logic              slot_free;
  logic [7:0]        count_inc;

  assign cfg.ready = 1'b1;

  assign runs.valid      = out_valid;
  assign runs.run_value  = out_value;
  assign runs.run_length = out_length;
  assign runs.final_run  = out_final;

  // distance to the run value on the full 9-bit signed range
  assign delta     = {open_value[7], open_value} - {q_cmd.diff[7], q_cmd.diff};
  assign mag       = delta[8] ? 9'(-delta) : 9'(delta);
  assign similar   = (mag <= {1'b0, threshold}) && (open_count < luma_dtr_pkg::RUN_CAP);
  assign brk       = run_active && !similar;
  assign count_inc = 8'(open_count + 8'd1);

  // a request that emits must find the output slot free
  assign need_out  = brk || q_cmd.eoi;
  assign slot_free = !out_valid || runs.ready;
  assign q_pop     = q_valid && !pend_valid && (!need_out || slot_free);

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 8'd0;
    end else if (cfg.valid) begin
      threshold <= cfg.data;
    end
  end

  // run state update
  always_ff @(posedge clk) begin
    if (rst) begin
      open_value <= '0;
      open_count <= 8'd0;
      run_active <= 1'b0;
    end else if (q_pop) begin
      if (q_cmd.eoi) begin
        open_value <= '0;
        open_count <= 8'd0;
        run_active <= 1'b0;
      end else if (!run_active || brk) begin
        open_value <= q_cmd.diff;
        open_count <= 8'd1;
        run_active <= 1'b1;
      end else begin
        open_count <= count_inc;
      end
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && slot_free) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_pop && need_out) begin
        out_valid  <= 1'b1;
        pend_valid <= brk && q_cmd.eoi;
      end else if (runs.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pend_valid && slot_free) begin
      out_value  <= pend_value;
      out_length <= 8'd1;
      out_final  <= 1'b1;
    end else if (q_pop && need_out) begin
      if (brk) begin
        out_value  <= open_value;
        out_length <= open_count;
        out_final  <= 1'b0;
        pend_value <= q_cmd.diff;
      end else if (run_active) begin
        out_value  <= open_value;
        out_length <= count_inc;
        out_final  <= 1'b1;
      end else begin
        out_value  <= q_cmd.diff;
        out_length <= 8'd1;
        out_final  <= 1'b1;
      end
    end
  end

  `LDTR_ASSERT(a_pend_has_out, !pend_valid || out_valid)
  `LDTR_ASSERT(a_active_count, run_active == (open_count != 8'd0))
  `LDTR_ASSERT(a_count_cap, open_count <= luma_dtr_pkg::RUN_CAP)
  `LDTR_ASSERT_NEXT(a_eoi_closes, q_pop && q_cmd.eoi, !run_active)

endmodule

// ===== sv/luma_difference_threshold_rle_unit.sv =====
// top level of the luma difference threshold run-length unit
// depends on luma_dtr_pkg, the three channel interfaces, front, fifo and back
//
// Channels: pix takes one pixel request per cycle while pix.ready is high
// (main_luma, compl_luma, end_of_image); runs gives run requests (run_value,
// run_length, final_run); cfg writes the similarity threshold and is always
// ready, to be used only while no pixel is in flight.
// After the pixel that closes it is accepted, a run passes the front stage,
// the queue and the output register before it is valid on runs, and it is
// taken at the next edge with runs.ready high.
// Throughput: one pixel per cycle while the queue is not full. A pixel that
// both breaks a run and ends the image yields two runs, which leave the single
// output register in turn. Reset (rst, synchronous): no run open, threshold 0,
// queue and output empty. When runs is stalled the output holds, the back stops
// draining the four entry queue at a request that emits a run, and the front
// stage drops pix.ready once the queue is full and the stage holds a pixel.
module luma_difference_threshold_rle_unit (
  input  logic            clk,
  input  logic            rst,
  luma_dtr_pixel_if.sink  pix,
  luma_dtr_run_if.source  runs,
  luma_dtr_cfg_if.sink    cfg
);

  logic               push;
  luma_dtr_pkg::cmd_t push_cmd;
  logic               push_ready;
  logic               q_valid;
  luma_dtr_pkg::cmd_t q_cmd;
  logic               q_pop;

  // difference stage
  luma_dtr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pix        (pix),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // decoupling queue
  luma_dtr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop        (q_pop)
  );

  // run tracking and output
  luma_dtr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .runs    (runs)
  );

endmodule

// ===== verif/luma_difference_threshold_rle_unit_tb.sv =====
// testbench for luma_difference_threshold_rle_unit: pixel stream in, run requests out
// depends on luma_dtr_pkg and the pixel, run and config channel interfaces
// a run tracker predicts every run from accepted pixels and checks them in order
module luma_difference_threshold_rle_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int RX_FREE = 0;

  typedef struct {
    logic signed [7:0] run_value;
    logic [7:0]        run_length;
    logic              final_run;
  } run_t;

  // tracks the open run and the runs still owed by the block
  class run_tracker;
    logic [7:0]        threshold;
    logic signed [7:0] open_value;
    logic [7:0]        open_count;
    bit                run_active;
    run_t              owed_runs[$];
    int                errors;

    function new();
      threshold  = '0;
      open_value = '0;
      open_count = '0;
      run_active = 1'b0;
      errors     = 0;
    endfunction

    function void set_threshold(logic [7:0] thr);
      threshold = thr;
    endfunction

    // one accepted pixel request: extend, break or flush the open run
    function void note_pixel(logic [7:0] main_luma, logic [7:0] compl_luma, logic eoi);
      logic signed [7:0] diff;
      int                delta;
      diff = main_luma - compl_luma;
      if (!run_active) begin
        open_value = diff;
        open_count = 8'd1;
        run_active = 1'b1;
      end else begin
        delta = int'(open_value) - int'(diff);
        if (delta < 0) delta = -delta;
        if (delta <= int'(threshold) && open_count < luma_dtr_pkg::RUN_CAP) begin
          open_count = open_count + 8'd1;
        end else begin
          owed_runs.push_back(run_t'{open_value, open_count, 1'b0});
          open_value = diff;
          open_count = 8'd1;
        end
      end
      if (eoi) begin
        owed_runs.push_back(run_t'{open_value, open_count, 1'b1});
        open_value = '0;
        open_count = '0;
        run_active = 1'b0;
      end
    endfunction

    // one accepted run request against the oldest owed run
    function void check_run(run_t got);
      run_t want;
      if (owed_runs.size() == 0) begin
        $error("unexpected run: run_value %0d run_length %0d final_run %0b",
               got.run_value, got.run_length, got.final_run);
        errors++;
        return;
      end
      want = owed_runs.pop_front();
      if (got.run_value !== want.run_value) begin
        $error("run_value: expected %0d, actual %0d", want.run_value, got.run_value);
        errors++;
      end
      if (got.run_length !== want.run_length) begin
        $error("run_length: expected %0d, actual %0d", want.run_length, got.run_length);
        errors++;
      end
      if (got.final_run !== want.final_run) begin
        $error("final_run: expected %0b, actual %0b", want.final_run, got.final_run);
        errors++;
      end
    endfunction

    function int owed();
      return owed_runs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  luma_dtr_pixel_if pix_bus ();
  luma_dtr_run_if   run_bus ();
  luma_dtr_cfg_if   cfg_bus ();

  luma_difference_threshold_rle_unit dut (
    .clk  (clk),
    .rst  (rst),
    .pix  (pix_bus),
    .runs (run_bus),
    .cfg  (cfg_bus)
  );

  run_tracker tracker = new();

  // sender and receiver pacing controls
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int rx_style = RX_FREE;
  bit long_hold_req = 1'b0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // observe accepted requests on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_bus.valid && pix_bus.ready)
        tracker.note_pixel(pix_bus.main_luma, pix_bus.compl_luma, pix_bus.end_of_image);
      if (run_bus.valid && run_bus.ready)
        tracker.check_run(run_t'{run_bus.run_value, run_bus.run_length, run_bus.final_run});
    end
  end

  // receiver: long hold-off on request, else free or a random pattern from an 8-bit mask
  initial begin
    logic [2:0]  phase_cnt;
    logic [7:0]  mask;
    phase_cnt = 3'd0;
    mask = 8'hff;
    run_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        run_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (phase_cnt == 3'd0) mask = (rx_style == RX_FREE) ? 8'hff : 8'($urandom);
        run_bus.ready <= mask[phase_cnt];
        phase_cnt = phase_cnt + 3'd1;
      end
    end
  end

  // one pixel request, with bursts and random gaps between them
  task automatic send_pixel(logic [7:0] main_luma, logic [7:0] compl_luma, logic eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          pix_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    pix_bus.valid        <= 1'b1;
    pix_bus.main_luma    <= main_luma;
    pix_bus.compl_luma   <= compl_luma;
    pix_bus.end_of_image <= eoi;
    do @(posedge clk); while (!pix_bus.ready);
    burst_left--;
  endtask

  // stop sending and let every owed run come out, then let the pipe settle
  task automatic wait_drained();
    pix_bus.valid <= 1'b0;
    burst_left = 0;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // threshold write, only while the block is idle
  task automatic write_threshold(logic [7:0] thr);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= thr;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    tracker.set_threshold(thr);
  endtask

  // one image: differences mostly clustered near a base, some pure noise
  task automatic send_image(int len, logic [7:0] thr);
    logic [7:0] base;
    logic [7:0] diff;
    logic [7:0] main_luma;
    logic [7:0] compl_luma;
    int         jit;
    int         off;
    base = 8'($urandom);
    jit = (thr >= 8'd254) ? 255 : int'(thr) + 1;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) base = 8'($urandom);
      main_luma = 8'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        off = $urandom_range(0, jit);
        if ($urandom_range(0, 1)) off = -off;
        diff = 8'(int'(base) + off);
        compl_luma = main_luma - diff;
      end else begin
        compl_luma = 8'($urandom);
      end
      send_pixel(main_luma, compl_luma, i == len - 1);
    end
  endtask

  // one random phase under a fixed threshold
  task automatic run_phase(logic [7:0] thr, int budget, bit long_image);
    int sent;
    int len;
    wait_drained();
    write_threshold(thr);
    rx_style = $urandom_range(0, 2);
    gaps_on = ($urandom_range(0, 3) != 0);
    sent = 0;
    // long image at full threshold reaches the run length cap
    if (long_image) begin
      len = $urandom_range(256, 262);
      send_image(len, thr);
      sent += len;
    end
    while (sent < budget) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      send_image(len, thr);
      sent += len;
    end
  endtask

  // timeout
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // main sequence
  initial begin
    rst                  <= 1'b1;
    pix_bus.valid        <= 1'b0;
    pix_bus.main_luma    <= '0;
    pix_bus.compl_luma   <= '0;
    pix_bus.end_of_image <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.data         <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset threshold 0: single-pixel image, extremes, break plus flush
    rx_style = 1;
    send_pixel(8'd0, 8'd0, 1'b1);
    send_pixel(8'd127, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd255, 1'b1);
    // wrapped differences equal to -1 form one run
    send_pixel(8'd0, 8'd1, 1'b0);
    send_pixel(8'd1, 8'd2, 1'b0);
    send_pixel(8'd255, 8'd0, 1'b0);
    send_pixel(8'd200, 8'd201, 1'b1);

    // threshold edge: distance equal to threshold extends, one more breaks
    wait_drained();
    write_threshold(8'd10);
    send_pixel(8'd10, 8'd0, 1'b0);
    send_pixel(8'd20, 8'd0, 1'b0);
    send_pixel(8'd21, 8'd0, 1'b0);
    send_pixel(8'd11, 8'd0, 1'b1);

    // distance beyond the signed byte range compares without wrap
    wait_drained();
    write_threshold(8'd200);
    send_pixel(8'd100, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd100, 1'b0);
    send_pixel(8'd0, 8'd101, 1'b0);
    send_pixel(8'd0, 8'd228, 1'b1);

    // full threshold: opposite extremes still one run
    wait_drained();
    write_threshold(8'd255);
    send_pixel(8'd127, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd0, 1'b1);

    // backpressure: receiver holds off while every pixel breaks a run
    wait_drained();
    write_threshold(8'd0);
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_pixel(8'(i * 7), 8'd0, i == 39);

    // random phases over several thresholds
    run_phase(8'd255, 270, 1'b1);
    run_phase(8'd0, 16, 1'b0);
    run_phase(8'd1, 16, 1'b0);
    run_phase(8'($urandom_range(2, 254)), 16, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 16, 1'b0);
    run_phase(8'($urandom_range(0, 31)), 16, 1'b0);

    wait_drained();
    if (tracker.errors == 0 && tracker.owed() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
